### rtl/spq_pkg.sv
// Package: shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int PRIO_BITS        = 8;
    localparam int REQ_PRIO_BITS    = 9;
    localparam int REQ_WORD_BITS    = 32;
    localparam int OCC_BITS         = 5;

    localparam logic [REQ_PRIO_BITS-1:0] PRIO_MAX = 9'd255;

    // Request kinds
    typedef enum logic [1:0] {
        K_INSERT    = 2'd0,
        K_REM_HEAD  = 2'd1,
        K_REM_EXACT = 2'd2,
        K_REM_ABOVE = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADPRIO  = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_PUT,
        S_REM_RD,
        S_REM_CMP,
        S_SH_RD,
        S_SH_WR
    } t_state;

    // Memory port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // Result handoff from sequencer to output register
    typedef struct packed {
        logic                 valid;
        t_status              status;
        logic [PRIO_BITS-1:0] prio;
    } t_res;

endpackage
`default_nettype wire

### rtl/spq_mem.sv
// Entry store: priority and payload arrays, one write and one registered read port.
`default_nettype none
module spq_mem
    import spq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int AW          = $clog2(DEPTH)
) (
    input  wire logic                    i_clk,
    input  wire t_mem_ctl                i_ctl,
    input  wire logic [AW-1:0]           i_wr_addr,
    input  wire logic [PRIO_BITS-1:0]    i_wr_prio,
    input  wire logic [PAYLOAD_BITS-1:0] i_wr_word,
    input  wire logic [AW-1:0]           i_rd_addr,
    output logic      [PRIO_BITS-1:0]    o_rd_prio,
    output logic      [PAYLOAD_BITS-1:0] o_rd_word
);

    logic [PRIO_BITS-1:0]    r_prio_mem [DEPTH];
    logic [PAYLOAD_BITS-1:0] r_word_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_prio_mem[i_wr_addr] <= i_wr_prio;
            r_word_mem[i_wr_addr] <= i_wr_word;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_prio <= r_prio_mem[i_rd_addr];
            o_rd_word <= r_word_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/spq_ctrl.sv
// Sequencer: walks the entry store one cell per step with a shared comparator.
`default_nettype none
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int AW          = $clog2(DEPTH),
    localparam int CW          = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request side
    input  wire logic                     i_req_valid,
    input  wire t_kind                    i_req_kind,
    input  wire logic [REQ_PRIO_BITS-1:0] i_req_prio,
    input  wire logic [PAYLOAD_BITS-1:0]  i_req_word,
    output logic                          o_idle,
    // result side
    output t_res                          o_res,
    output logic      [PAYLOAD_BITS-1:0]  o_res_word,
    output logic      [CW-1:0]            o_count,
    input  wire logic                     i_res_ready,
    // entry store
    output t_mem_ctl                      o_mem_ctl,
    output logic      [AW-1:0]            o_wr_addr,
    output logic      [PRIO_BITS-1:0]     o_wr_prio,
    output logic      [PAYLOAD_BITS-1:0]  o_wr_word,
    output logic      [AW-1:0]            o_rd_addr,
    input  wire logic [PRIO_BITS-1:0]     i_rd_prio,
    input  wire logic [PAYLOAD_BITS-1:0]  i_rd_word
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state                   r_state, n_state;
    t_kind                    r_kind;
    logic [REQ_PRIO_BITS-1:0] r_prio;
    logic [PAYLOAD_BITS-1:0]  r_word;
    logic [CW-1:0]            r_pos;
    logic [CW-1:0]            r_count;
    t_status                  r_status;
    logic [PRIO_BITS-1:0]     r_rprio;
    logic [PAYLOAD_BITS-1:0]  r_rword;
    logic                     r_done;

    logic [CW-1:0]            pos_m1;
    logic [CW-1:0]            pos_p1;
    logic [REQ_PRIO_BITS-1:0] cmp_a;
    logic                     cmp_hit;

    assign pos_m1 = r_pos - 1'b1;
    assign pos_p1 = r_pos + 1'b1;

    // Shared comparator: stored priority against the request priority
    assign cmp_a = {1'b0, i_rd_prio};
    always_comb begin
        case (r_kind)
            K_REM_HEAD:  cmp_hit = 1'b1;
            K_REM_EXACT: cmp_hit = (cmp_a == r_prio);
            default:     cmp_hit = (cmp_a > r_prio);
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && !r_done) begin
                    if (i_req_kind == K_INSERT) begin
                        if (i_req_prio <= PRIO_MAX && r_count != FULL_COUNT) begin
                            n_state = S_INS_RD;
                        end
                    end else if (r_count != '0) begin
                        n_state = S_REM_RD;
                    end
                end
            end
            S_INS_RD:  n_state = (r_pos == '0) ? S_PUT : S_INS_CMP;
            S_INS_CMP: n_state = cmp_hit ? S_INS_RD : S_PUT;
            S_PUT:     n_state = S_IDLE;
            S_REM_RD:  n_state = S_REM_CMP;
            S_REM_CMP: begin
                if (cmp_hit) begin
                    n_state = S_SH_RD;
                end else if (pos_p1 == r_count) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_REM_RD;
                end
            end
            S_SH_RD:   n_state = (pos_p1 >= r_count) ? S_IDLE : S_SH_WR;
            S_SH_WR:   n_state = S_SH_RD;
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory strobes and addresses
    always_comb begin
        o_mem_ctl = '0;
        o_wr_addr = r_pos[AW-1:0];
        o_wr_prio = i_rd_prio;
        o_wr_word = i_rd_word;
        o_rd_addr = r_pos[AW-1:0];
        case (r_state)
            S_INS_RD: begin
                o_mem_ctl.rd_en = (r_pos != '0);
                o_rd_addr       = pos_m1[AW-1:0];
            end
            S_INS_CMP: o_mem_ctl.wr_en = cmp_hit;
            S_PUT: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_prio       = r_prio[PRIO_BITS-1:0];
                o_wr_word       = r_word;
            end
            S_REM_RD:  o_mem_ctl.rd_en = 1'b1;
            S_SH_RD: begin
                o_mem_ctl.rd_en = (pos_p1 < r_count);
                o_rd_addr       = pos_p1[AW-1:0];
            end
            S_SH_WR:   o_mem_ctl.wr_en = 1'b1;
            default: begin
                o_mem_ctl = '0;
            end
        endcase
    end

    // State register and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PUT) begin
                r_count <= r_count + 1'b1;
            end else if (r_state == S_SH_RD && pos_p1 >= r_count) begin
                r_count <= r_count - 1'b1;
            end
            // result pending until the output register takes it
            if (r_done && i_res_ready) begin
                r_done <= 1'b0;
            end else if ((r_state != S_IDLE && n_state == S_IDLE) ||
                         (r_state == S_IDLE && i_req_valid && !r_done &&
                          n_state == S_IDLE)) begin
                r_done <= 1'b1;
            end
        end
    end

    // Working registers and result capture
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && !r_done) begin
                    r_kind  <= i_req_kind;
                    r_prio  <= i_req_prio;
                    r_word  <= i_req_word;
                    r_rprio <= '0;
                    r_rword <= '0;
                    r_status <= ST_OK;
                    if (i_req_kind == K_INSERT) begin
                        r_pos <= r_count;
                        if (i_req_prio > PRIO_MAX) begin
                            r_status <= ST_BADPRIO;
                        end else if (r_count == FULL_COUNT) begin
                            r_status <= ST_FULL;
                        end
                    end else begin
                        r_pos <= '0;
                        if (r_count == '0) begin
                            r_status <= ST_EMPTY;
                        end
                    end
                end
            end
            S_INS_CMP: begin
                if (cmp_hit) begin
                    r_pos <= pos_m1;
                end
            end
            S_REM_CMP: begin
                if (cmp_hit) begin
                    r_rprio <= i_rd_prio;
                    r_rword <= i_rd_word;
                end else if (pos_p1 == r_count) begin
                    r_status <= ST_NOTFOUND;
                end else begin
                    r_pos <= pos_p1;
                end
            end
            S_SH_WR: r_pos <= pos_p1;
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_idle       = (r_state == S_IDLE) && !r_done;
        o_res.valid  = r_done;
        o_res.status = r_status;
        o_res.prio   = r_rprio;
        o_res_word   = r_rword;
        o_count      = r_count;
    end

    // Count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above capacity");

    // Walk pointer stays inside the occupied range or one past its end
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_pos <= r_count))
        else $error("walk pointer beyond occupied cells");

    // Count moves only when an insert lands or a removal shift ends
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> ($past(r_state) == S_PUT || $past(r_state) == S_SH_RD))
        else $error("entry count changed outside insert or removal");

    // No new request while a result is pending
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("sequencer busy with an undelivered result");

endmodule
`default_nettype wire

### rtl/sorted_priority_queue_top.sv
// Top level: request handshake, entry store, sequencer and result register.
// Operation: an insert reads and compares cells from the tail toward the head, moving up
//   each entry of larger priority value, then writes the new entry; a removal reads and
//   compares from the head to a hit or the end, then shifts the later entries down.
// Throughput: one transaction at a time, the next accepted once the result register holds
//   the last one; each visited cell needs a read step first (single registered read port).
// Reset: synchronous active low; clears the count and control, store unchanged.
`default_nettype none
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [1:0]               i_kind,
    input  wire logic [REQ_PRIO_BITS-1:0] i_prio,
    input  wire logic [REQ_WORD_BITS-1:0] i_payload,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic      [2:0]               o_status,
    output logic      [PRIO_BITS-1:0]     o_out_prio,
    output logic      [REQ_WORD_BITS-1:0] o_out_payload,
    output logic      [OCC_BITS-1:0]      o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_mem_ctl                  mem_ctl;
    logic [AW-1:0]             wr_addr, rd_addr;
    logic [PRIO_BITS-1:0]      wr_prio, rd_prio;
    logic [PAYLOAD_BITS-1:0]   wr_word, rd_word;
    logic [PAYLOAD_BITS-1:0]   req_word;
    logic [PAYLOAD_BITS+REQ_WORD_BITS-1:0] req_ext;
    logic [REQ_WORD_BITS+PAYLOAD_BITS-1:0] res_ext;
    logic [CW+OCC_BITS-1:0]    occ_ext;
    t_res                      res;
    logic [PAYLOAD_BITS-1:0]   res_word;
    logic [CW-1:0]             count;
    logic                      idle;
    logic                      res_ready;

    logic                      r_valid;
    t_status                   r_status;
    logic [PRIO_BITS-1:0]      r_prio;
    logic [REQ_WORD_BITS-1:0]  r_word;
    logic [OCC_BITS-1:0]       r_occ;

    // Width fitting of the payload and count
    assign req_ext  = {{PAYLOAD_BITS{1'b0}}, i_payload};
    assign req_word = req_ext[PAYLOAD_BITS-1:0];
    assign res_ext  = {{REQ_WORD_BITS{1'b0}}, res_word};
    assign occ_ext  = {{OCC_BITS{1'b0}}, count};

    assign o_ready   = idle;
    assign res_ready = !r_valid || i_ready;

    spq_mem #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_prio (wr_prio),
        .i_wr_word (wr_word),
        .i_rd_addr (rd_addr),
        .o_rd_prio (rd_prio),
        .o_rd_word (rd_word)
    );

    spq_ctrl #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_kind  (t_kind'(i_kind)),
        .i_req_prio  (i_prio),
        .i_req_word  (req_word),
        .o_idle      (idle),
        .o_res       (res),
        .o_res_word  (res_word),
        .o_count     (count),
        .i_res_ready (res_ready),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_prio   (wr_prio),
        .o_wr_word   (wr_word),
        .o_rd_addr   (rd_addr),
        .i_rd_prio   (rd_prio),
        .i_rd_word   (rd_word)
    );

    // Result register: holds a transaction until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_status <= res.status;
            r_prio   <= res.prio;
            r_word   <= res_ext[REQ_WORD_BITS-1:0];
            r_occ    <= occ_ext[OCC_BITS-1:0];
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_prio    = r_prio;
    assign o_out_payload = r_word;
    assign o_occupancy   = r_occ;

endmodule
`default_nettype wire

### sim/testbench.sv
// Testbench for the sorted priority queue: random traffic, behavioral predictor, result checks.
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    localparam int ENTRIES     = DEPTH_DEF;
    localparam int NUM_ITEMS   = 1550;
    localparam int DRAIN_WAIT  = 2 * ENTRIES + 40;

    typedef struct packed {
        t_kind                    kind;
        logic [REQ_PRIO_BITS-1:0] prio;
        logic [REQ_WORD_BITS-1:0] payload;
    } t_request;

    typedef struct packed {
        t_status                  status;
        logic [PRIO_BITS-1:0]     prio;
        logic [REQ_WORD_BITS-1:0] payload;
        logic [OCC_BITS-1:0]      occ;
    } t_outcome;

    // Traffic shaping of the random part
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     i_valid   = 1'b0;
    logic                     o_ready;
    logic [1:0]               i_kind    = K_INSERT;
    logic [REQ_PRIO_BITS-1:0] i_prio    = '0;
    logic [REQ_WORD_BITS-1:0] i_payload = '0;
    logic                     o_valid;
    logic                     i_ready   = 1'b0;
    logic [2:0]               o_status;
    logic [PRIO_BITS-1:0]     o_out_prio;
    logic [REQ_WORD_BITS-1:0] o_out_payload;
    logic [OCC_BITS-1:0]      o_occupancy;

    // Requests waiting to be sent, results waiting to arrive
    t_request pending_q[$];
    t_outcome outcome_q[$];

    // Predicted queue contents, head at index 0
    logic [PRIO_BITS-1:0]     held_prio[ENTRIES];
    logic [REQ_WORD_BITS-1:0] held_word[ENTRIES];
    int                       held_cnt = 0;

    int err_cnt      = 0;
    int sent_cnt     = 0;
    int checked_cnt  = 0;
    int ins_ok_cnt   = 0;
    int full_cnt     = 0;
    int badprio_cnt  = 0;
    int removed_cnt  = 0;
    int empty_cnt    = 0;
    int notfound_cnt = 0;

    // Sender burst/gap counters
    int       burst_left = 8;
    int       gap_left   = 0;
    logic     send_now;
    t_request head_req;

    // Receiver stall pattern
    logic [15:0] ready_pat  = 16'hFFFF;
    int          pat_left   = 32;
    t_outcome    exp_res;

    sorted_priority_queue_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_prio        (i_prio),
        .i_payload     (i_payload),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_out_prio    (o_out_prio),
        .o_out_payload (o_out_payload),
        .o_occupancy   (o_occupancy)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one request to the predicted queue and return its result
    function automatic t_outcome queue_apply(t_request rq);
        t_outcome res;
        int       pos;
        int       i;
        logic     hit;
        res.status  = ST_OK;
        res.prio    = '0;
        res.payload = '0;
        pos = 0;
        hit = 1'b0;
        if (rq.kind == K_INSERT) begin
            if (rq.prio > PRIO_MAX) begin
                res.status = ST_BADPRIO;
                badprio_cnt++;
            end else if (held_cnt >= ENTRIES) begin
                res.status = ST_FULL;
                full_cnt++;
            end else begin
                // goes behind every entry of equal or lower priority
                while (pos < held_cnt && held_prio[pos] <= rq.prio[PRIO_BITS-1:0])
                    pos++;
                for (i = held_cnt; i > pos; i--) begin
                    held_prio[i] = held_prio[i-1];
                    held_word[i] = held_word[i-1];
                end
                held_prio[pos] = rq.prio[PRIO_BITS-1:0];
                held_word[pos] = rq.payload;
                held_cnt++;
                ins_ok_cnt++;
            end
        end else if (held_cnt == 0) begin
            res.status = ST_EMPTY;
            empty_cnt++;
        end else begin
            if (rq.kind == K_REM_HEAD) begin
                hit = 1'b1;
            end else begin
                while (pos < held_cnt && !hit) begin
                    if (rq.kind == K_REM_EXACT)
                        hit = ({1'b0, held_prio[pos]} == rq.prio);
                    else
                        hit = ({1'b0, held_prio[pos]} > rq.prio);
                    if (!hit)
                        pos++;
                end
            end
            if (hit) begin
                res.prio    = held_prio[pos];
                res.payload = held_word[pos];
                for (i = pos; i + 1 < held_cnt; i++) begin
                    held_prio[i] = held_prio[i+1];
                    held_word[i] = held_word[i+1];
                end
                held_cnt--;
                removed_cnt++;
            end else begin
                res.status = ST_NOTFOUND;
                notfound_cnt++;
            end
        end
        res.occ = OCC_BITS'(held_cnt);
        return res;
    endfunction

    task automatic add_req(t_kind k, int p, logic [REQ_WORD_BITS-1:0] w);
        t_request rq;
        rq.kind    = k;
        rq.prio    = REQ_PRIO_BITS'(p);
        rq.payload = w;
        pending_q.push_back(rq);
    endtask

    // Mostly a narrow range so exact matches hit, with full-range and invalid values
    function automatic logic [REQ_PRIO_BITS-1:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return REQ_PRIO_BITS'($urandom_range(0, 15));
        else if (r < 85)
            return REQ_PRIO_BITS'($urandom_range(0, 255));
        else if (r < 93)
            return ($urandom_range(0, 1) != 0) ? PRIO_MAX : '0;
        else
            return REQ_PRIO_BITS'($urandom_range(256, 511));
    endfunction

    function automatic t_kind pick_kind(t_mix mix);
        int r;
        int ins_pct;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  ins_pct = 85;
            MIX_DRAIN: ins_pct = 15;
            default:   ins_pct = 50;
        endcase
        if (r < ins_pct)
            return K_INSERT;
        case ($urandom_range(0, 2))
            0:       return K_REM_HEAD;
            1:       return K_REM_EXACT;
            default: return K_REM_ABOVE;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 4);
        else
            return $urandom_range(5, 20);
    endfunction

    // Driver: presents pending requests in bursts, predicts each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            send_now = i_valid;
            if (i_valid && o_ready) begin
                head_req = pending_q.pop_front();
                outcome_q.push_back(queue_apply(head_req));
                sent_cnt++;
                send_now = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    gap_left   = pick_gap();
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 24);
                end
            end
            if (!send_now) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    head_req = pending_q[0];
                    send_now = 1'b1;
                    i_kind    <= head_req.kind;
                    i_prio    <= head_req.prio;
                    i_payload <= head_req.payload;
                end
            end
            i_valid <= send_now;
        end
    end

    // Monitor: checks each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result: status %0d prio %0d payload %h occupancy %0d",
                       o_status, o_out_prio, o_out_payload, o_occupancy);
                err_cnt++;
            end else begin
                exp_res = outcome_q.pop_front();
                checked_cnt++;
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    err_cnt++;
                end
                if (o_out_prio !== exp_res.prio) begin
                    $error("out_prio: expected %0d, got %0d", exp_res.prio, o_out_prio);
                    err_cnt++;
                end
                if (o_out_payload !== exp_res.payload) begin
                    $error("out_payload: expected %h, got %h", exp_res.payload, o_out_payload);
                    err_cnt++;
                end
                if (o_occupancy !== exp_res.occ) begin
                    $error("occupancy: expected %0d, got %0d", exp_res.occ, o_occupancy);
                    err_cnt++;
                end
            end
        end

        // rotating stall pattern, reloaded now and then; never all zero
        i_ready   <= ready_pat[0];
        ready_pat  = {ready_pat[0], ready_pat[15:1]};
        pat_left--;
        if (pat_left <= 0) begin
            pat_left = $urandom_range(16, 200);
            case ($urandom_range(0, 3))
                0:       ready_pat = 16'hFFFF;
                1:       ready_pat = 16'($urandom()) | 16'h0001;
                2:       ready_pat = (16'($urandom()) & 16'($urandom())) | 16'h8001;
                default: ready_pat = 16'($urandom()) | 16'h0101;
            endcase
        end
    end

    // Stimulus, reset and end of run
    initial begin
        t_mix  mix;
        int    seg_len;
        int    n;
        t_kind k;

        // directed: empty queue, bounds, equal priorities, misses
        add_req(K_REM_HEAD,  0,   32'h0000_0000);
        add_req(K_REM_EXACT, 0,   32'hFFFF_FFFF);
        add_req(K_REM_ABOVE, 511, 32'h1234_5678);
        add_req(K_INSERT,    256, 32'h0000_0001);
        add_req(K_INSERT,    511, 32'hFFFF_FFFF);
        add_req(K_INSERT,    255, 32'hFFFF_FFFF);
        add_req(K_INSERT,    0,   32'h0000_0000);
        add_req(K_INSERT,    128, 32'hA5A5_A5A5);
        add_req(K_INSERT,    128, 32'h5A5A_5A5A);
        add_req(K_REM_EXACT, 384, 32'h0);
        add_req(K_REM_EXACT, 7,   32'h0);
        add_req(K_REM_ABOVE, 255, 32'h0);
        add_req(K_REM_ABOVE, 511, 32'h0);
        add_req(K_REM_EXACT, 128, 32'hDEAD_BEEF);
        add_req(K_REM_ABOVE, 0,   32'h0);
        add_req(K_REM_HEAD,  0,   32'h0);
        add_req(K_REM_EXACT, 255, 32'h0);
        add_req(K_REM_HEAD,  0,   32'h0);
        add_req(K_REM_ABOVE, 0,   32'h0);

        // random segments: fill runs lean toward full, drain runs toward empty
        n = pending_q.size();
        while (n < NUM_ITEMS) begin
            mix     = t_mix'($urandom_range(0, 2));
            seg_len = $urandom_range(10, 40);
            repeat (seg_len) begin
                k = pick_kind(mix);
                pending_q.push_back(t_request'{k, pick_prio(), 32'($urandom())});
                n++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all requests sent and all results seen
        @(negedge i_clk);
        while (pending_q.size() != 0 || i_valid || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Run covered %0d requests, %0d results checked:", sent_cnt, checked_cnt);
        $display("  %0d inserts, %0d full, %0d bad priority; removals: %0d taken, %0d empty, %0d missed",
                 ins_ok_cnt, full_cnt, badprio_cnt, removed_cnt, empty_cnt, notfound_cnt);
        if (err_cnt == 0 && outcome_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("timeout: %0d results still outstanding", outcome_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
rtl/spq_pkg.sv
rtl/spq_mem.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue_top.sv
sim/testbench.sv
